/* rtl/aadd_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive audio delta decoder package
// Shared constants and types of the one-channel adaptive prediction decoder.
// ----------------------------------------------------------------------------
package aadd_pkg;

  localparam int ADAPT_PERIOD_LOG2 = 5;
  localparam int NUM_COEFS         = 5;
  localparam int NUM_SUMS          = 2 * NUM_COEFS + 1;
  localparam int SUM_W             = 16;
  localparam int COEF_W            = 6;
  localparam int IDX_W             = $clog2(NUM_SUMS);
  localparam int KIDX_W            = $clog2(NUM_COEFS);

  typedef logic        [SUM_W-1:0]             sum_t;
  typedef logic signed [COEF_W-1:0]            coef_t;
  typedef logic        [ADAPT_PERIOD_LOG2-1:0] count_t;

  localparam coef_t COEF_DEC_LIMIT = -6'sd16;
  localparam coef_t COEF_INC_LIMIT = 6'sd16;
  localparam sum_t  SUM_SAT        = '1;

  typedef struct packed {
    sum_t             val;
    logic [IDX_W-1:0] idx;
  } min_t;

endpackage

/* rtl/adaptive_audio_delta_decoder.sv */
// ----------------------------------------------------------------------------
// Adaptive audio delta decoder
// One channel of an adaptive linear-prediction audio delta decoder.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle while the output side is not
// stalled, and returns one result per request.
// A request is captured in an input register; the prediction, error tracking
// and coefficient adaptation for it are computed combinationally from the
// channel state and written to the result register and the state together,
// so the next request always sees the state left by the previous one. The
// sustained rate of one request per cycle is set by that combinational update.
module adaptive_audio_delta_decoder
  import aadd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        coded_delta_i,
  input  logic signed [7:0] neighbor_delta_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        sample_out_o,
  output logic signed [7:0] new_neighbor_delta_o
);

  function automatic logic signed [14:0] coef_mul(coef_t c, logic signed [8:0] h);
    logic signed [14:0] ce;
    logic signed [14:0] he;
    ce = {{(15 - COEF_W){c[COEF_W-1]}}, c};
    he = {{6{h[8]}}, h};
    return ce * he;
  endfunction

  function automatic sum_t acc_err(sum_t s, logic signed [12:0] diff);
    logic [11:0] mag;
    logic [16:0] tot;
    mag = diff[12] ? 12'(-diff) : diff[11:0];
    tot = {1'b0, s} + {5'b0, mag};
    return tot[16] ? SUM_SAT : tot[15:0];
  endfunction

  function automatic min_t pick(min_t a, min_t b);
    return (b.val < a.val) ? b : a;
  endfunction

  logic              in_valid_q;
  logic [7:0]        coded_q;
  logic signed [7:0] nb_q;
  logic              out_valid_q;
  logic [7:0]        sample_q;
  logic signed [7:0] delta_q;

  logic [7:0]        prev_sample_q;
  logic signed [7:0] prev_delta_q;
  logic signed [7:0] hist_one_q;
  logic signed [8:0] hist_two_q;
  logic signed [8:0] hist_three_q;
  coef_t             coef_q [NUM_COEFS];
  sum_t              sums_q [NUM_SUMS];
  count_t            count_q;

  coef_t             coef_d [NUM_COEFS];
  sum_t              sums_d [NUM_SUMS];
  sum_t              sums_acc [NUM_SUMS];
  count_t            count_d;

  logic              fire;
  logic signed [8:0] hist_one_x;
  logic signed [8:0] hist_two_d;
  logic signed [8:0] nb_x;
  logic signed [16:0] acc;
  logic [7:0]        sample_d;
  logic [7:0]        delta_d;
  logic signed [12:0] scaled;
  logic              adapt;
  min_t              lvl1 [6];
  min_t              lvl2 [3];
  min_t              lvl3 [2];
  min_t              best;
  logic [IDX_W-1:0]  best_m1;
  logic [KIDX_W-1:0] kidx;

  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign sample_out_o         = sample_q;
  assign new_neighbor_delta_o = delta_q;

  always_comb begin
    hist_one_x = {prev_delta_q[7], prev_delta_q};
    hist_two_d = hist_one_x - {hist_one_q[7], hist_one_q};
    nb_x       = {nb_q[7], nb_q};

    acc = {6'b0, prev_sample_q, 3'b0}
        + 17'(coef_mul(coef_q[0], hist_one_x))
        + 17'(coef_mul(coef_q[1], hist_two_d))
        + 17'(coef_mul(coef_q[2], hist_two_q))
        + 17'(coef_mul(coef_q[3], hist_three_q))
        + 17'(coef_mul(coef_q[4], nb_x));
    sample_d = acc[10:3] - coded_q;
    delta_d  = sample_d - prev_sample_q;

    scaled = {{2{coded_q[7]}}, coded_q, 3'b0};
    sums_acc[0]  = acc_err(sums_q[0], scaled);
    sums_acc[1]  = acc_err(sums_q[1], scaled - 13'(hist_one_x));
    sums_acc[2]  = acc_err(sums_q[2], scaled + 13'(hist_one_x));
    sums_acc[3]  = acc_err(sums_q[3], scaled - 13'(hist_two_d));
    sums_acc[4]  = acc_err(sums_q[4], scaled + 13'(hist_two_d));
    sums_acc[5]  = acc_err(sums_q[5], scaled - 13'(hist_two_q));
    sums_acc[6]  = acc_err(sums_q[6], scaled + 13'(hist_two_q));
    sums_acc[7]  = acc_err(sums_q[7], scaled - 13'(hist_three_q));
    sums_acc[8]  = acc_err(sums_q[8], scaled + 13'(hist_three_q));
    sums_acc[9]  = acc_err(sums_q[9], scaled - 13'(nb_x));
    sums_acc[10] = acc_err(sums_q[10], scaled + 13'(nb_x));

    for (int i = 0; i < 5; i++) begin
      lvl1[i] = pick(min_t'{val: sums_acc[2*i], idx: IDX_W'(2*i)},
                     min_t'{val: sums_acc[2*i+1], idx: IDX_W'(2*i+1)});
    end
    lvl1[5] = '{val: sums_acc[10], idx: IDX_W'(10)};
    for (int i = 0; i < 3; i++) begin
      lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
    end
    lvl3[0] = pick(lvl2[0], lvl2[1]);
    lvl3[1] = lvl2[2];
    best    = pick(lvl3[0], lvl3[1]);
    best_m1 = best.idx - IDX_W'(1);
    kidx    = best_m1[KIDX_W:1];

    count_d = count_q + count_t'(1);
    adapt   = (count_d == '0);

    coef_d = coef_q;
    for (int i = 0; i < NUM_SUMS; i++) begin
      sums_d[i] = adapt ? '0 : sums_acc[i];
    end
    if (adapt && (best.idx != '0)) begin
      if (best.idx[0]) begin
        if (coef_q[kidx] >= COEF_DEC_LIMIT) begin
          coef_d[kidx] = coef_q[kidx] - coef_t'(1);
        end
      end else begin
        if (coef_q[kidx] < COEF_INC_LIMIT) begin
          coef_d[kidx] = coef_q[kidx] + coef_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      coded_q <= coded_delta_i;
      nb_q    <= neighbor_delta_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      sample_q <= sample_d;
      delta_q  <= delta_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q <= '0;
      prev_delta_q  <= '0;
      hist_one_q    <= '0;
      hist_two_q    <= '0;
      hist_three_q  <= '0;
      count_q       <= '0;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= '0;
      end
      for (int i = 0; i < NUM_SUMS; i++) begin
        sums_q[i] <= '0;
      end
    end else if (fire) begin
      prev_sample_q <= sample_d;
      prev_delta_q  <= delta_d;
      hist_one_q    <= prev_delta_q;
      hist_two_q    <= hist_two_d;
      hist_three_q  <= hist_two_q;
      count_q       <= count_d;
      coef_q        <= coef_d;
      sums_q        <= sums_d;
    end
  end

endmodule
